/* rtl/haversine_distance_top_defines.svh */
// assertion macros for the haversine distance block
// used by haversine_distance_top; no other dependencies
`ifndef HAVERSINE_DISTANCE_TOP_DEFINES_SVH
`define HAVERSINE_DISTANCE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HVD_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
	else $error("haversine distance check failed");

// next-cycle implication, disabled while reset is asserted
`define HVD_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
	else $error("haversine distance check failed");

`endif

/* rtl/hvd_pkg.sv */
// shared constants and elaboration-time tables for the haversine distance block
// no dependencies
`default_nettype none

package hvd_pkg;

	localparam int ANGLE_FRACTION_BITS_DEF = 30;
	localparam int CORDIC_STAGES_DEF       = 32;

	localparam int LAT_W    = 31;
	localparam int LON_W    = 32;
	localparam int RADIUS_W = 24;
	localparam int DIST_W   = 26;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
	localparam logic [DIST_W-1:0]   DIST_MAX     = {DIST_W{1'b1}};

	// angle difference in units of 5e-8 degree
	localparam int ANG_IN_W = 34;
	// folded angle, at most a quarter turn
	localparam int FOLD_W   = 31;

	localparam logic [ANG_IN_W-1:0] FULL_TURN    = 34'd7200000000;
	localparam logic [ANG_IN_W-1:0] HALF_TURN    = 34'd3600000000;
	localparam logic [ANG_IN_W-1:0] QUARTER_TURN = 34'd1800000000;

	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

	// pi / 3.6e9 in units of 2^-78
	localparam logic [63:0] RAD_Q = PI_Q62 / 64'd3600000000;
	localparam logic [63:0] RAD_R = PI_Q62 % 64'd3600000000;
	localparam logic [63:0] RAD_SCALE =
		(RAD_Q << 16) + ((RAD_R << 16) + 64'd1800000000) / 64'd3600000000;
	localparam int RAD_W     = 48;
	localparam int RAD_SPLIT = 24;
	localparam logic [RAD_SPLIT-1:0]       RAD_LO = RAD_SCALE[RAD_SPLIT-1:0];
	localparam logic [RAD_W-RAD_SPLIT-1:0] RAD_HI = RAD_SCALE[RAD_W-1:RAD_SPLIT];

	// gain correction split point
	localparam int K2_LO_W = 31;
	localparam int K2_HI_W = 30;

	// unsigned quotient by shift and subtract, elaboration only
	function automatic logic [63:0] quot_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		int b;
		quo = '0;
		rem = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// step angle atan(2^-i) in Q(fb), built from a truncated series in Q0.62
	function automatic logic [63:0] atan_q(input int i, input int fb);
		logic [63:0] acc;
		logic [63:0] term;
		int k;
		acc = 64'd0;
		if (i == 0) begin
			acc = PI_Q62 >> 2;
		end else begin
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				term = quot_u64((64'd1 << 62) >> (i * (2 * k + 1)), 64'(2 * k + 1));
				if (k[0]) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
		end
		return (acc + (64'd1 << (61 - fb))) >> (62 - fb);
	endfunction

	// inverse squared cordic gain in Q0.62
	function automatic logic [63:0] gain_sq(input int stages);
		logic [63:0] k;
		int i;
		k = 64'd1 << 61;
		for (i = 1; i < stages && 2 * i <= 61; i++) begin
			k = k - quot_u64(k, (64'd1 << (2 * i)) + 64'd1);
		end
		return k;
	endfunction

endpackage

`default_nettype wire

/* rtl/hvd_fold.sv */
// angle reduction: wraps, folds to a quarter turn and scales to fixed-point radians
// depends on hvd_pkg
`default_nettype none

module hvd_fold import hvd_pkg::*; #(
	parameter int FB = ANGLE_FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [ANG_IN_W-1:0] ang,
	output logic signed [FB+2:0]       z,
	output logic                       neg
);

	localparam int SH    = 78 - FB;
	localparam int PH_W  = FOLD_W + RAD_W - RAD_SPLIT;
	localparam int PL_W  = FOLD_W + RAD_SPLIT;
	localparam int SUM_W = FOLD_W + RAD_W + 1;

	logic signed [ANG_IN_W-1:0] ang_s1;
	logic [ANG_IN_W-2:0]        mag_s2;
	logic [ANG_IN_W-3:0]        half_s3;
	logic [FOLD_W-1:0]          quad_s4;
	logic                       neg_s4, neg_s5, neg_s6;
	logic [PH_W-1:0]            ph_s5;
	logic [PL_W-1:0]            pl_s5;
	logic signed [FB+2:0]       z_s6;

	logic [ANG_IN_W-1:0] abs_v;
	logic [ANG_IN_W-1:0] mod_v;
	logic [ANG_IN_W-1:0] mag_x;
	logic [ANG_IN_W-1:0] half_x;
	logic [SUM_W-1:0]    sum_v;

	assign abs_v  = ang_s1[ANG_IN_W-1] ? ANG_IN_W'(-ang_s1) : ANG_IN_W'(ang_s1);
	assign mod_v  = (abs_v >= FULL_TURN) ? abs_v - FULL_TURN : abs_v;
	assign mag_x  = ANG_IN_W'(mag_s2);
	assign half_x = ANG_IN_W'(half_s3);
	assign sum_v  = (SUM_W'(ph_s5) << RAD_SPLIT) + SUM_W'(pl_s5) + (SUM_W'(1) << (SH - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang;
			mag_s2 <= (ANG_IN_W-1)'(mod_v);
			// past half a turn, mirror back
			half_s3 <= (mag_x > HALF_TURN) ? (ANG_IN_W-2)'(FULL_TURN - mag_x)
				: (ANG_IN_W-2)'(mag_x);
			// past a quarter turn, mirror and flip the cosine
			if (half_x > QUARTER_TURN) begin
				quad_s4 <= FOLD_W'(HALF_TURN - half_x);
				neg_s4  <= 1'b1;
			end else begin
				quad_s4 <= FOLD_W'(half_x);
				neg_s4  <= 1'b0;
			end
			ph_s5  <= PH_W'(quad_s4) * PH_W'(RAD_HI);
			pl_s5  <= PL_W'(quad_s4) * PL_W'(RAD_LO);
			neg_s5 <= neg_s4;
			z_s6   <= signed'((FB+3)'(sum_v >> SH));
			neg_s6 <= neg_s5;
		end
	end

	assign z   = z_s6;
	assign neg = neg_s6;

endmodule

`default_nettype wire

/* rtl/hvd_cordic_cell.sv */
// one cordic micro-rotation, rotation or vectoring mode
// depends on hvd_pkg
`default_nettype none

module hvd_cordic_cell import hvd_pkg::*; #(
	parameter int              W      = ANGLE_FRACTION_BITS_DEF + 3,
	parameter int              SHIFT  = 0,
	parameter logic [W-1:0]    ATAN   = '0,
	parameter bit              VECTOR = 1'b0
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] x_i,
	input  logic signed [W-1:0] y_i,
	input  logic signed [W-1:0] z_i,
	output logic signed [W-1:0] x_o,
	output logic signed [W-1:0] y_o,
	output logic signed [W-1:0] z_o
);

	logic signed [W-1:0] x_s1, y_s1, z_s1;
	logic signed [W-1:0] xs, ys, at;
	logic                ccw;

	assign xs  = x_i >>> SHIFT;
	assign ys  = y_i >>> SHIFT;
	assign at  = signed'(ATAN);
	// vectoring drives y to zero, rotation drives z to zero
	assign ccw = VECTOR ? y_i[W-1] : !z_i[W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (ccw) begin
				x_s1 <= x_i - ys;
				y_s1 <= y_i + xs;
				z_s1 <= z_i - at;
			end else begin
				x_s1 <= x_i + ys;
				y_s1 <= y_i - xs;
				z_s1 <= z_i + at;
			end
		end
	end

	assign x_o = x_s1;
	assign y_o = y_s1;
	assign z_o = z_s1;

endmodule

`default_nettype wire

/* rtl/hvd_sqrt_cell.sv */
// one bit of a restoring square root, remainder form
// depends on hvd_pkg
`default_nettype none

module hvd_sqrt_cell import hvd_pkg::*; #(
	parameter int W  = 2 * ANGLE_FRACTION_BITS_DEF + 2,
	parameter int RW = ANGLE_FRACTION_BITS_DEF + 1,
	parameter int B  = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  rem_i,
	input  logic [RW-1:0] res_i,
	output logic [W-1:0]  rem_o,
	output logic [RW-1:0] res_o
);

	logic [W-1:0]  rem_s1;
	logic [RW-1:0] res_s1;
	logic [W-1:0]  trial;

	// (res + 2^b)^2 - res^2
	assign trial = (W'(res_i) << (B + 1)) + (W'(1) << (2 * B));

	always_ff @(posedge clk) begin
		if (en) begin
			if (trial <= rem_i) begin
				rem_s1 <= rem_i - trial;
				res_s1 <= res_i | (RW'(1) << B);
			end else begin
				rem_s1 <= rem_i;
				res_s1 <= res_i;
			end
		end
	end

	assign rem_o = rem_s1;
	assign res_o = res_s1;

endmodule

`default_nettype wire

/* rtl/haversine_distance_top.sv */
// haversine great-circle distance, top level
// depends on hvd_pkg, hvd_fold, hvd_cordic_cell, hvd_sqrt_cell and the defines header
//
// usage
//   input channel (in_valid / in_ready) takes one beat holding two points,
//   latitude and longitude in units of 1e-7 degree. output channel
//   (out_valid / out_ready) returns one beat per input beat: the distance in
//   whole metres, rounded half up, saturated at 2^26-1.
//   sphere_radius_we / sphere_radius_wdata write the sphere radius in metres;
//   write only while no beat is in flight.
// throughput and pipeline
//   one beat per cycle sustained while the output is taken. from accept to
//   out_valid a beat passes 6 fold stages, a cordic rotation chain, 7 product
//   stages, one square root cell per result bit, a cordic vectoring chain, the
//   radius product and the output register.
// reset
//   arst_n clears all valid bits and the output valid; the radius returns to
//   6371000. no clearing pass is needed.
// stall
//   the output register parts the pipe from the receiver. while it holds a
//   beat that is not taken, the pipe keeps moving and in_ready stays high
//   until a valid beat reaches the last stage; then the whole pipe holds.
`default_nettype none
`include "haversine_distance_top_defines.svh"

module haversine_distance_top import hvd_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF,
	parameter int CORDIC_STAGES       = CORDIC_STAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [LAT_W-1:0]    start_latitude,
	input  logic signed [LON_W-1:0]    start_longitude,
	input  logic signed [LAT_W-1:0]    end_latitude,
	input  logic signed [LON_W-1:0]    end_longitude,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [DIST_W-1:0]          distance,
	input  logic                       sphere_radius_we,
	input  logic [RADIUS_W-1:0]        sphere_radius_wdata
);

	localparam int FB  = ANGLE_FRACTION_BITS;
	localparam int N   = CORDIC_STAGES;
	localparam int ZW  = FB + 3;          // cordic datapath width
	localparam int MW  = FB + 2;          // magnitude of a cordic output
	localparam int RQ  = FB + 2;          // rounded square or product
	localparam int GW  = FB + 1;          // gain-corrected term
	localparam int RW  = 2 * FB + 2;      // square root remainder
	localparam int SW  = FB + 1;          // square root result
	localparam int PW  = FB + 2 + RADIUS_W;
	localparam int L   = 6 + N + 7 + (FB + 1) + N + 1;

	localparam logic [63:0] K2 = gain_sq(N);
	localparam logic [K2_LO_W-1:0] K2_LO = K2[K2_LO_W-1:0];
	localparam logic [K2_HI_W-1:0] K2_HI = K2[K2_LO_W+K2_HI_W-1:K2_LO_W];
	localparam logic signed [ZW-1:0] X_INIT = {2'b00, 1'b1, {FB{1'b0}}};
	localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

	// handshake and flow control
	logic [L-1:0]        vld_q;
	logic                out_valid_q;
	logic [DIST_W-1:0]   distance_q;
	logic [RADIUS_W-1:0] radius_q;
	logic                out_load;
	logic                en;

	// a valid beat in the last stage moves only into a free output register
	assign out_load = !out_valid_q || out_ready;
	assign en       = out_load || !vld_q[L-1];
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (sphere_radius_we) begin
			radius_q <= sphere_radius_wdata;
		end
	end

	// four angles: dlat/2, dlon/2, lat1, lat2, all in 5e-8 degree
	logic signed [ANG_IN_W-1:0] ang_in [4];
	logic signed [ZW-1:0]       fz [4];
	logic [3:0]                 fneg;

	assign ang_in[0] = ANG_IN_W'(start_latitude) - ANG_IN_W'(end_latitude);
	assign ang_in[1] = ANG_IN_W'(end_longitude) - ANG_IN_W'(start_longitude);
	assign ang_in[2] = ANG_IN_W'(start_latitude) <<< 1;
	assign ang_in[3] = ANG_IN_W'(end_latitude) <<< 1;

	// rotation chains, one lane per angle
	logic signed [ZW-1:0] rx [4][N+1];
	logic signed [ZW-1:0] ry [4][N+1];
	logic signed [ZW-1:0] rz [4][N+1];
	logic [3:0]           neg_dly_q [N];

	genvar ln, st;
	generate
		for (ln = 0; ln < 4; ln++) begin : g_lane
			hvd_fold #(.FB(FB)) u_fold (
				.clk (clk),
				.en  (en),
				.ang (ang_in[ln]),
				.z   (fz[ln]),
				.neg (fneg[ln])
			);
			assign rx[ln][0] = X_INIT;
			assign ry[ln][0] = '0;
			assign rz[ln][0] = fz[ln];
			for (st = 0; st < N; st++) begin : g_rot
				localparam logic [ZW-1:0] AT = ZW'(atan_q(st, FB));
				hvd_cordic_cell #(.W(ZW), .SHIFT(st), .ATAN(AT), .VECTOR(1'b0)) u_cell (
					.clk (clk),
					.en  (en),
					.x_i (rx[ln][st]),
					.y_i (ry[ln][st]),
					.z_i (rz[ln][st]),
					.x_o (rx[ln][st+1]),
					.y_o (ry[ln][st+1]),
					.z_o (rz[ln][st+1])
				);
			end
		end
	endgenerate

	// cosine sign flags ride along the rotation chain
	always_ff @(posedge clk) begin
		if (en) begin
			neg_dly_q[0] <= fneg;
			for (int j = 1; j < N; j++) begin
				neg_dly_q[j] <= neg_dly_q[j-1];
			end
		end
	end

	// products: sin^2(dlat/2), sin^2(dlon/2), cos(lat1)cos(lat2)
	logic signed [ZW-1:0] ya, yb, x1, x2;
	logic [MW-1:0]        ma, mb, m1, m2;
	logic                 sgn;

	assign ya  = ry[0][N];
	assign yb  = ry[1][N];
	assign x1  = rx[2][N];
	assign x2  = rx[3][N];
	assign ma  = ya[ZW-1] ? MW'(-ya) : MW'(ya);
	assign mb  = yb[ZW-1] ? MW'(-yb) : MW'(yb);
	assign m1  = x1[ZW-1] ? MW'(-x1) : MW'(x1);
	assign m2  = x2[ZW-1] ? MW'(-x2) : MW'(x2);
	// product term subtracts when the two cosines differ in sign
	assign sgn = (neg_dly_q[N-1][2] ^ x1[ZW-1]) ^ (neg_dly_q[N-1][3] ^ x2[ZW-1]);

	logic [2*MW-1:0]        sq_s1 [3];
	logic [RQ-1:0]          rq_s2 [3];
	logic [RQ+K2_HI_W-1:0]  kh_s3 [3];
	logic [RQ+K2_LO_W-1:0]  kl_s3 [3];
	logic [GW-1:0]          g_s4  [3];
	logic [2*GW-1:0]        t2p_s5;
	logic [GW-1:0]          sa_s5, sa_s6;
	logic [FB+1:0]          t2_s6;
	logic [FB:0]            h_s7;
	logic [6:1]             sgn_s;

	logic [MW-1:0]         op_a [3];
	logic [MW-1:0]         op_b [3];
	logic [RQ+62-1:0]      ksum [3];
	logic signed [FB+2:0]  hs;
	logic [FB:0]           hu;

	assign op_a[0] = ma;
	assign op_b[0] = ma;
	assign op_a[1] = mb;
	assign op_b[1] = mb;
	assign op_a[2] = m1;
	assign op_b[2] = m2;

	generate
		for (ln = 0; ln < 3; ln++) begin : g_term
			assign ksum[ln] = ((RQ+62)'(kh_s3[ln]) << K2_LO_W) + (RQ+62)'(kl_s3[ln])
				+ ((RQ+62)'(1) << 61);
			always_ff @(posedge clk) begin
				if (en) begin
					sq_s1[ln] <= (2*MW)'(op_a[ln]) * (2*MW)'(op_b[ln]);
					rq_s2[ln] <= RQ'((sq_s1[ln] + ((2*MW)'(1) << (FB - 1))) >> FB);
					kh_s3[ln] <= (RQ+K2_HI_W)'(rq_s2[ln]) * (RQ+K2_HI_W)'(K2_HI);
					kl_s3[ln] <= (RQ+K2_LO_W)'(rq_s2[ln]) * (RQ+K2_LO_W)'(K2_LO);
					g_s4[ln]  <= GW'(ksum[ln] >> 62);
				end
			end
		end
	endgenerate

	assign hs = sgn_s[6] ? $signed({2'b00, sa_s6}) - $signed({1'b0, t2_s6})
		: $signed({2'b00, sa_s6}) + $signed({1'b0, t2_s6});
	// h clamped to [0, 1]
	assign hu = hs[FB+2] ? '0 : (hs > $signed({2'b00, ONE})) ? ONE : hs[FB:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s[1] <= sgn;
			for (int j = 2; j <= 6; j++) begin
				sgn_s[j] <= sgn_s[j-1];
			end
			t2p_s5 <= (2*GW)'(g_s4[2]) * (2*GW)'(g_s4[1]);
			sa_s5  <= g_s4[0];
			t2_s6  <= (FB+2)'((t2p_s5 + ((2*GW)'(1) << (FB - 1))) >> FB);
			sa_s6  <= sa_s5;
			h_s7   <= hu;
		end
	end

	// square roots of h and 1-h, one cell per result bit
	logic [RW-1:0] srem [2][FB+2];
	logic [SW-1:0] sres [2][FB+2];

	assign srem[0][0] = RW'(h_s7) << FB;
	assign srem[1][0] = RW'(ONE - h_s7) << FB;
	assign sres[0][0] = '0;
	assign sres[1][0] = '0;

	generate
		for (ln = 0; ln < 2; ln++) begin : g_root
			for (st = 0; st <= FB; st++) begin : g_bit
				hvd_sqrt_cell #(.W(RW), .RW(SW), .B(FB - st)) u_cell (
					.clk   (clk),
					.en    (en),
					.rem_i (srem[ln][st]),
					.res_i (sres[ln][st]),
					.rem_o (srem[ln][st+1]),
					.res_o (sres[ln][st+1])
				);
			end
		end
	endgenerate

	// vectoring chain: angle of (sqrt(1-h), sqrt h)
	logic signed [ZW-1:0] vx [N+1];
	logic signed [ZW-1:0] vy [N+1];
	logic signed [ZW-1:0] vz [N+1];

	assign vx[0] = $signed({2'b00, sres[1][FB+1]});
	assign vy[0] = $signed({2'b00, sres[0][FB+1]});
	assign vz[0] = '0;

	generate
		for (st = 0; st < N; st++) begin : g_vec
			localparam logic [ZW-1:0] AT = ZW'(atan_q(st, FB));
			hvd_cordic_cell #(.W(ZW), .SHIFT(st), .ATAN(AT), .VECTOR(1'b1)) u_cell (
				.clk (clk),
				.en  (en),
				.x_i (vx[st]),
				.y_i (vy[st]),
				.z_i (vz[st]),
				.x_o (vx[st+1]),
				.y_o (vy[st+1]),
				.z_o (vz[st+1])
			);
		end
	endgenerate

	// distance = 2 * angle * radius, rounded and saturated
	logic [FB:0]     zc;
	logic [PW-1:0]   prod_s8;
	logic [PW:0]     dsum;
	logic [PW-FB:0]  dval;

	assign zc   = vz[N][ZW-1] ? '0 : vz[N][FB:0];
	assign dsum = (PW+1)'(prod_s8) + ((PW+1)'(1) << (FB - 1));
	assign dval = (PW-FB+1)'(dsum >> FB);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s8 <= PW'({zc, 1'b0}) * PW'(radius_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= vld_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			distance_q <= (dval > (PW-FB+1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(dval);
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;

	// a stalled beat in the last stage is never dropped
	`HVD_ASSERT_NXT(a_stall_keeps_beat, clk, arst_n, out_valid_q && !out_ready && vld_q[L-1], vld_q[L-1] && out_valid_q)
	// output valid only rises from a beat in the last stage
	`HVD_ASSERT_IMP(a_out_from_pipe, clk, arst_n, $rose(out_valid_q), $past(vld_q[L-1]))
	// an accepted beat enters the first stage
	`HVD_ASSERT_NXT(a_accept_enters, clk, arst_n, in_valid && in_ready, vld_q[0])

endmodule

`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench for haversine_distance_top (great-circle distance)
// depends on hvd_pkg and the rtl top level; a bit-exact predictor runs alongside
`timescale 1ns / 100ps

module testbench import hvd_pkg::*; ();

	localparam int FB = 30;           // angle fraction bits
	localparam int NSTAGE = 32;       // cordic stages
	localparam int LATENCY = 2 * NSTAGE + FB + 16;
	localparam int RANDOM_PER_PHASE = 135;
	localparam int NPHASE = 6;

	localparam longint FULL_U = 64'sd7200000000;
	localparam longint HALF_U = 64'sd3600000000;
	localparam longint QUART_U = 64'sd1800000000;
	localparam logic [63:0] PI62 = 64'hC90FDAA22168C235;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [LAT_W-1:0] start_latitude = '0;
	logic signed [LON_W-1:0] start_longitude = '0;
	logic signed [LAT_W-1:0] end_latitude = '0;
	logic signed [LON_W-1:0] end_longitude = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIST_W-1:0] distance;
	logic sphere_radius_we = 1'b0;
	logic [RADIUS_W-1:0] sphere_radius_wdata = '0;

	haversine_distance_top DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.start_latitude      (start_latitude),
		.start_longitude     (start_longitude),
		.end_latitude        (end_latitude),
		.end_longitude       (end_longitude),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.distance            (distance),
		.sphere_radius_we    (sphere_radius_we),
		.sphere_radius_wdata (sphere_radius_wdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of the radius register
	logic [RADIUS_W-1:0] radius_now = RADIUS_RESET;
	// distances still owed by the block, oldest first
	logic [DIST_W-1:0] owed_dist[$];
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	bit calm = 1'b0;       // no idling on either side while set
	longint arc_tab[NSTAGE];
	longint unsigned k2_gain;

	// round(a*b / 2^s), half up, kept to 64 bits
	function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
		return p[63 + s -: 64];
	endfunction

	// atan(2^-i) in Q(FB), from a truncated series in Q0.62
	function automatic longint arc_of(int i);
		logic [63:0] acc;
		logic [63:0] term;
		int k;
		acc = 64'd0;
		if (i == 0) begin
			acc = PI62 >> 2;
		end else begin
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				term = ((64'd1 << 62) >> (i * (2 * k + 1))) / 64'(2 * k + 1);
				if (k % 2 == 1) acc = acc - term;
				else acc = acc + term;
			end
		end
		return longint'((acc + (64'd1 << (61 - FB))) >> (62 - FB));
	endfunction

	// angle in 5e-8 degree -> radians in [0, pi/2]; flag set when folded past a quarter turn
	function automatic longint to_radians(longint a, output bit flip);
		longint unsigned q, r, c;
		q = PI62 / 64'd3600000000;
		r = PI62 % 64'd3600000000;
		c = (q << 16) + ((r << 16) + 64'd1800000000) / 64'd3600000000;
		a = a % FULL_U;
		if (a < 0) a = -a;
		if (a > HALF_U) a = FULL_U - a;
		flip = 1'b0;
		if (a > QUART_U) begin
			a = HALF_U - a;
			flip = 1'b1;
		end
		return longint'(mul_round(longint'(a), c, 78 - FB));
	endfunction

	function automatic void sin_cos(longint z, output longint cx, output longint sy);
		longint x, y, xs, ys;
		x = longint'(1) <<< FB;
		y = 0;
		for (int i = 0; i < NSTAGE; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arc_tab[i];
			end else begin
				x += ys; y -= xs; z += arc_tab[i];
			end
		end
		cx = x;
		sy = y;
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// floor(sqrt(h * 2^FB))
	function automatic longint unsigned root_fb(longint unsigned h);
		logic [127:0] t, sq;
		longint unsigned res, cand;
		t = {64'd0, h} << FB;
		res = 0;
		for (int b = FB; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			sq = {64'd0, cand} * {64'd0, cand};
			if (sq <= t) res = cand;
		end
		return res;
	endfunction

	function automatic logic [DIST_W-1:0] predict_distance(longint la1, longint lo1,
			longint la2, longint lo2);
		bit f0, f1, f2, f3;
		longint xa, ya, xb, yb, x1, y1, x2, y2, h, z, x, y, xs, ys;
		longint unsigned sa, sb, cc, t2, hu, one, d;
		one = 64'd1 << FB;
		sin_cos(to_radians(la1 - la2, f0), xa, ya);
		sin_cos(to_radians(lo2 - lo1, f1), xb, yb);
		sin_cos(to_radians(2 * la1, f2), x1, y1);
		sin_cos(to_radians(2 * la2, f3), x2, y2);
		sa = mul_round(mul_round(magn(ya), magn(ya), FB), k2_gain, 62);
		sb = mul_round(mul_round(magn(yb), magn(yb), FB), k2_gain, 62);
		cc = mul_round(mul_round(magn(x1), magn(x2), FB), k2_gain, 62);
		t2 = mul_round(cc, sb, FB);
		// the cosine product sign combines fold flips and cordic signs
		if ((f2 != (x1 < 0)) != (f3 != (x2 < 0))) h = longint'(sa) - longint'(t2);
		else h = longint'(sa) + longint'(t2);
		if (h < 0) h = 0;
		if (h > longint'(one)) h = longint'(one);
		hu = h;
		x = longint'(root_fb(one - hu));
		y = longint'(root_fb(hu));
		z = 0;
		for (int i = 0; i < NSTAGE; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += arc_tab[i];
			end else begin
				x -= ys; y += xs; z -= arc_tab[i];
			end
		end
		if (z < 0) z = 0;
		d = (radius_now == 0) ? 0 : mul_round(longint'(z) * 2, 64'(radius_now), FB);
		if (d > 64'(DIST_MAX)) d = 64'(DIST_MAX);
		return d[DIST_W-1:0];
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drive one point pair and wait until the beat is taken
	task automatic send_pair(longint la1, longint lo1, longint la2, longint lo2,
			bit fixed, logic [DIST_W-1:0] fixed_dist);
		logic signed [LAT_W-1:0] a1, a2;
		logic signed [LON_W-1:0] o1, o2;
		int gap;
		a1 = la1[LAT_W-1:0];
		o1 = lo1[LON_W-1:0];
		a2 = la2[LAT_W-1:0];
		o2 = lo2[LON_W-1:0];
		start_latitude <= a1;
		start_longitude <= o1;
		end_latitude <= a2;
		end_longitude <= o2;
		in_valid <= 1'b1;
		// in_ready settles between edges, so look at it on the falling edge
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		owed_dist.push_back(fixed ? fixed_dist :
			predict_distance(longint'(a1), longint'(o1), longint'(a2), longint'(o2)));
		beats_in++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_pair();
		longint la1, lo1, la2, lo2;
		int mode;
		mode = $urandom_range(0, 9);
		la1 = longint'($urandom_range(0, 1800000000)) - 900000000;
		lo1 = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
		la2 = longint'($urandom_range(0, 1800000000)) - 900000000;
		lo2 = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
		case (mode)
			0: begin
				// raw bit patterns, far out of range too
				la1 = longint'($signed($urandom()));
				lo1 = longint'($signed($urandom()));
				la2 = longint'($signed($urandom()));
				lo2 = longint'($signed($urandom()));
			end
			1: begin
				// nearly the same point
				la2 = la1 + longint'($urandom_range(0, 2000)) - 1000;
				lo2 = lo1 + longint'($urandom_range(0, 2000)) - 1000;
			end
			2: begin
				// near the antipode
				la2 = -la1 + longint'($urandom_range(0, 200)) - 100;
				lo2 = lo1 + 1800000000 + longint'($urandom_range(0, 200)) - 100;
			end
			default: ;
		endcase
		send_pair(la1, lo1, la2, lo2, 1'b0, '0);
	endtask

	typedef struct {
		longint la1, lo1, la2, lo2;
		bit fixed;
		logic [DIST_W-1:0] exp_dist;
	} pair_row_t;

	// directed rows; the first three, where both points coincide, have zero distance typed in
	pair_row_t pair_rows[] = '{
		'{0, 0, 0, 0, 1'b1, 0},
		'{900000000, 1800000000, 900000000, 1800000000, 1'b1, 0},
		'{-900000000, -1800000000, -900000000, -1800000000, 1'b1, 0},
		'{900000000, 0, -900000000, 0, 1'b0, 0},          // pole to pole
		'{0, 0, 0, 1800000000, 1'b0, 0},                  // antipodes on the equator
		'{0, -1800000000, 0, 1800000000, 1'b0, 0},        // same meridian, wrapped
		'{900000000, 123456789, 900000000, -987654321, 1'b0, 0},
		'{0, 0, 0, 1, 1'b0, 0},                           // smallest step
		'{1, 0, 0, 0, 1'b0, 0},
		'{-1073741824, -2147483648, 1073741823, 2147483647, 1'b0, 0}, // field extremes
		'{1073741823, 2147483647, -1073741824, -2147483648, 1'b0, 0},
		'{1000000000, 0, 1000000000, 0, 1'b0, 0},         // past the pole
		'{1000000000, 0, -1000000000, 900000000, 1'b0, 0},
		'{515000000, -1200000, 407000000, -740000000, 1'b0, 0},
		'{-338000000, 1512000000, 515000000, -1200000, 1'b0, 0},
		'{450000000, 900000000, -450000000, -900000000, 1'b0, 0},
		'{0, 900000000, 0, -900000000, 1'b0, 0},
		'{899999999, 0, -899999999, 1800000000, 1'b0, 0}
	};

	task automatic write_radius(logic [RADIUS_W-1:0] v);
		sphere_radius_we <= 1'b1;
		sphere_radius_wdata <= v;
		@(posedge clk);
		sphere_radius_we <= 1'b0;
		radius_now = v;
	endtask

	// stop offering beats and wait for the pipe to run dry before touching the register
	task automatic drain();
		in_valid <= 1'b0;
		while (owed_dist.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	// receiver: random stalls, a long one now and then
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (calm) begin
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				stall = pick_gap();
				out_ready <= (stall == 0);
			end
		end
	end

	// result checker, sampled between edges
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (owed_dist.size() == 0) begin
				$error("distance beat with nothing expected: actual %0d", distance);
				errors++;
			end else begin
				if (distance !== owed_dist[0]) begin
					$error("distance mismatch: expected %0d actual %0d",
						owed_dist[0], distance);
					errors++;
				end
				void'(owed_dist.pop_front());
			end
			beats_out++;
		end
	end

	initial begin
		logic [RADIUS_W-1:0] radius_plan[NPHASE];
		for (int i = 0; i < NSTAGE; i++) arc_tab[i] = arc_of(i);
		// inverse squared gain, Q0.62
		k2_gain = 64'd1 << 61;
		for (int i = 1; i < NSTAGE && 2 * i <= 61; i++)
			k2_gain = k2_gain - k2_gain / ((64'd1 << (2 * i)) + 64'd1);

		// reset value first and last, the extremes, zero and a random one between
		radius_plan[0] = RADIUS_RESET;
		radius_plan[1] = 24'd16777215;
		radius_plan[2] = 24'd1;
		radius_plan[3] = 24'd0;
		radius_plan[4] = RADIUS_W'($urandom_range(1, 16777215));
		radius_plan[5] = 24'd6371000;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < NPHASE; p++) begin
			if (p > 0) begin
				drain();
				write_radius(radius_plan[p]);
			end
			// last phase runs with no idling at all
			calm = (p == NPHASE - 1);
			if (p == 0) begin
				foreach (pair_rows[r])
					send_pair(pair_rows[r].la1, pair_rows[r].lo1, pair_rows[r].la2,
						pair_rows[r].lo2, pair_rows[r].fixed, pair_rows[r].exp_dist);
			end
			repeat (RANDOM_PER_PHASE) send_random_pair();
		end
		calm = 1'b0;
		drain();

		$display("ran %0d point pairs over %0d radius settings, %0d distances checked",
			beats_in, NPHASE, beats_out);
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#4ms;
		$display("timeout with %0d distances outstanding", owed_dist.size());
		$display("testbench NOT OK");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/hvd_pkg.sv
rtl/hvd_fold.sv
rtl/hvd_cordic_cell.sv
rtl/hvd_sqrt_cell.sv
rtl/haversine_distance_top.sv
dv/testbench.sv
